// ===== rtl/core/ple_pkg.sv =====
// Package for the positional list engine: sizes, request and status codes,
// and the per-cell command struct. No dependencies.
package ple_pkg;

    localparam int CAPACITY    = 64;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int WIDE_W      = 9;
    localparam int SLOT_W      = $clog2(CAPACITY);
    localparam int VAL_W       = 32;
    localparam int LEN_W       = 7;
    localparam int STATUS_W    = 2;
    localparam int KIND_W      = 3;
    localparam int POS_W       = 8;
    localparam int GROUP_SIZE  = 8;
    localparam int NGROUPS     = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    typedef enum logic [KIND_W-1:0] {
        KIND_INS_FRONT = 3'd0,
        KIND_INS_BACK  = 3'd1,
        KIND_INS_POS   = 3'd2,
        KIND_DEL_FRONT = 3'd3,
        KIND_DEL_BACK  = 3'd4,
        KIND_DEL_POS   = 3'd5,
        KIND_READ      = 3'd6
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_INS  = 2'd1,
        CMD_DEL  = 2'd2
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic              rd_en;
        logic [SLOT_W-1:0] slot;
        logic [VAL_W-1:0]  value;
    } cell_op_t;

endpackage

// ===== rtl/core/ple_cell.sv =====
// One list cell: holds one entry, shifts from its neighbors on insert/delete.
// Depends on ple_pkg.
module ple_cell (
    input  logic                          clk,
    input  ple_pkg::cell_op_t             op,
    input  logic [ple_pkg::SLOT_W-1:0]    idx,
    input  logic [ple_pkg::VAL_W-1:0]     left_data,
    input  logic [ple_pkg::VAL_W-1:0]     right_data,
    output logic [ple_pkg::VAL_W-1:0]     data,
    output logic [ple_pkg::VAL_W-1:0]     rd_data
);
    import ple_pkg::*;

    logic [VAL_W-1:0] data_reg;
    logic [VAL_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (op.cmd)
            CMD_INS:
            begin
                if (idx > op.slot)
                begin
                    data_next = left_data;
                end
                else if (idx == op.slot)
                begin
                    data_next = op.value;
                end
            end
            CMD_DEL:
            begin
                if (idx >= op.slot)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = (op.rd_en && (idx == op.slot)) ? data_reg : '0;

endmodule

// ===== rtl/core/ple_ctrl.sv =====
// Request decoder and entry counter: checks positions, issues cell commands.
// Depends on ple_pkg.
module ple_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [ple_pkg::KIND_W-1:0]  kind,
    input  logic [ple_pkg::POS_W-1:0]   position,
    input  logic [ple_pkg::VAL_W-1:0]   value,
    output ple_pkg::cell_op_t           op,
    output ple_pkg::status_t            status,
    output logic [ple_pkg::LEN_W-1:0]   length
);
    import ple_pkg::*;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [WIDE_W-1:0] cnt_w;
    logic [WIDE_W-1:0] pos_w;
    logic [WIDE_W-1:0] len_w;
    logic              full;
    logic              empty;

    assign cnt_w = WIDE_W'(count_reg);
    assign pos_w = WIDE_W'(position);
    assign full  = cnt_w >= WIDE_W'(CAPACITY);
    assign empty = count_reg == '0;

    always_comb
    begin
        op.cmd     = CMD_NONE;
        op.rd_en   = 1'b0;
        op.slot    = '0;
        op.value   = value;
        status     = ST_OK;
        count_next = count_reg;
        unique case (kind_t'(kind))
            KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_POS:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else if (kind_t'(kind) == KIND_INS_FRONT)
                begin
                    op.cmd     = CMD_INS;
                    count_next = count_reg + 1'b1;
                end
                else if (kind_t'(kind) == KIND_INS_BACK)
                begin
                    op.cmd     = CMD_INS;
                    op.slot    = SLOT_W'(count_reg);
                    count_next = count_reg + 1'b1;
                end
                else if (pos_w == '0 || pos_w > cnt_w + 1'b1)
                begin
                    status = ST_BADPOS;
                end
                else
                begin
                    op.cmd     = CMD_INS;
                    op.slot    = SLOT_W'(pos_w - 1'b1);
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_DEL_FRONT, KIND_DEL_BACK, KIND_DEL_POS:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else if (kind_t'(kind) == KIND_DEL_FRONT)
                begin
                    op.cmd     = CMD_DEL;
                    count_next = count_reg - 1'b1;
                end
                else if (kind_t'(kind) == KIND_DEL_BACK)
                begin
                    op.cmd     = CMD_DEL;
                    op.slot    = SLOT_W'(cnt_w - 1'b1);
                    count_next = count_reg - 1'b1;
                end
                else if (pos_w == '0 || pos_w > cnt_w)
                begin
                    status = ST_BADPOS;
                end
                else
                begin
                    op.cmd     = CMD_DEL;
                    op.slot    = SLOT_W'(pos_w - 1'b1);
                    count_next = count_reg - 1'b1;
                end
            end
            KIND_READ:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else if (pos_w == '0 || pos_w > cnt_w)
                begin
                    status = ST_BADPOS;
                end
                else
                begin
                    op.rd_en = 1'b1;
                    op.slot  = SLOT_W'(pos_w - 1'b1);
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
        if (!accept)
        begin
            op.cmd     = CMD_NONE;
            op.rd_en   = 1'b0;
            count_next = count_reg;
        end
    end

    assign len_w  = WIDE_W'(count_next);
    assign length = len_w[LEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/positional_list_engine.sv =====
// Positional list engine: each transaction's result passes the s1 registers, then
// the output registers (done strobe); a new transaction is taken every cycle (busy low).
// The cell row updates at the accept edge; a read passes a registered OR tree.
// Reset clears the entry count and the pipeline valid bits; cell contents stay
// undefined until written. Results cannot be stalled by the receiver.
module positional_list_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ple_pkg::KIND_W-1:0]    kind,
    input  logic [ple_pkg::POS_W-1:0]     position,
    input  logic signed [ple_pkg::VAL_W-1:0] value,
    output logic                          done,
    output logic [ple_pkg::STATUS_W-1:0]  status,
    output logic [ple_pkg::LEN_W-1:0]     length,
    output logic signed [ple_pkg::VAL_W-1:0] read_value
);
    import ple_pkg::*;

    logic             accept;
    cell_op_t         op;
    status_t          req_status;
    logic [LEN_W-1:0] req_length;

    logic [VAL_W-1:0] cell_data [CAPACITY];
    logic [VAL_W-1:0] cell_rd   [CAPACITY];
    logic [VAL_W-1:0] grp_next  [NGROUPS];
    logic [VAL_W-1:0] grp_reg   [NGROUPS];
    logic [VAL_W-1:0] rd_sum;

    logic             s1_valid_reg;
    status_t          s1_status_reg;
    logic [LEN_W-1:0] s1_length_reg;

    logic             done_reg;
    status_t          status_reg;
    logic [LEN_W-1:0] length_reg;
    logic [VAL_W-1:0] read_value_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    ple_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .kind     (kind),
        .position (position),
        .value    (value),
        .op       (op),
        .status   (req_status),
        .length   (req_length)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VAL_W-1:0] left_d;
        logic [VAL_W-1:0] right_d;
        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end
        ple_cell u_cell (
            .clk        (clk),
            .op         (op),
            .idx        (SLOT_W'(i)),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    for (genvar g = 0; g < NGROUPS; g++)
    begin : g_grp
        always_comb
        begin
            grp_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++)
            begin
                if (g * GROUP_SIZE + k < CAPACITY)
                begin
                    grp_next[g] = grp_next[g] | cell_rd[g * GROUP_SIZE + k];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            grp_reg[g] <= grp_next[g];
        end
    end

    always_comb
    begin
        rd_sum = '0;
        for (int g = 0; g < NGROUPS; g++)
        begin
            rd_sum = rd_sum | grp_reg[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_status_reg  <= req_status;
        s1_length_reg  <= req_length;
        status_reg     <= s1_status_reg;
        length_reg     <= s1_length_reg;
        read_value_reg <= rd_sum;
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign length     = length_reg;
    assign read_value = read_value_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("transaction result missing two cycles after accept");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(s1_valid_reg))
        else $error("result strobe without a transaction in flight");

    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> read_value == '0)
        else $error("nonzero read value on a failed transaction");

endmodule
